### src/hmt_pkg.sv
// Shared constants and types for the plurality vote histogram unit.
`timescale 1ns / 1ps
`default_nettype none

package hmt_pkg;

  localparam int CAND_BITS  = 10;
  localparam int COUNT_BITS = 16;
  localparam int EPOCH_BITS = 8;

  localparam int SLOTS      = 1 << CAND_BITS;
  localparam int DATA_BITS  = ((CAND_BITS + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [EPOCH_BITS-1:0] EPOCH_MAX   = {EPOCH_BITS{1'b1}};
  localparam logic [CAND_BITS-1:0]  CAND_MAX    = {CAND_BITS{1'b1}};
  localparam logic [CAND_BITS-1:0]  WINNER_NONE = '0;

  typedef logic [CAND_BITS-1:0]  cand_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [EPOCH_BITS-1:0] epoch_t;

  // One count memory word: the set it belongs to and its vote count.
  typedef struct packed {
    epoch_t tag;
    count_t count;
  } mem_entry_t;

endpackage

`default_nettype wire

### src/histogram_mode_with_tie_unit.sv
// Top level of the plurality vote histogram unit with tie detection.
//
//   channel  | dir | signals                          | payload
//   ---------+-----+----------------------------------+-------------------------------
//   ballots  | in  | s_tvalid s_tready s_tdata s_tlast| tdata[9:0] candidate, tlast set end
//   results  | out | m_tvalid m_tready m_tdata        | tdata[9:0] winner (0 on a tie)
//
// Cycles: one ballot per clock unless stalled; each ballot is one read-modify-write of the
//   count memory (read on accept, written back from the ballot stage, last write forwarded).
// Result: the last ballot passes through the ballot stage, then the result register.
// Reset: a clearing pass sweeps all 1024 words of the count memory; it repeats after
//   every 256th set when the 8-bit set tag wraps. s_tready stays low meanwhile.
// Stalls: a staged last ballot waits while the previous result is still held, and
//   s_tready drops behind it; a set ending on the last tag holds s_tready low.
`timescale 1ns / 1ps
`default_nettype none

module histogram_mode_with_tie_unit
  import hmt_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire [DATA_BITS-1:0]  s_tdata,   // [9:0] candidate, rest zero
  input  wire                  s_tlast,   // last ballot of the set
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [DATA_BITS-1:0] m_tdata    // [9:0] winner, rest zero
);

  // Count memory, tagged with the set it was written in.
  mem_entry_t mem [SLOTS];
  mem_entry_t rd_data;

  logic   clearing;
  cand_t  clr_addr;
  epoch_t epoch;

  // Stage holding the ballot whose count is being read.
  logic  s1_valid;
  cand_t s1_cand;
  logic  s1_last;

  // Last write, for a read issued on the same edge.
  logic   fwd_valid;
  cand_t  fwd_addr;
  count_t fwd_cnt;

  count_t best_count;
  cand_t  leader;
  logic   tied;
  cand_t  winner;

  count_t best_next;
  cand_t  leader_next;
  logic   tied_next;
  count_t base_cnt;
  count_t cnt_inc;
  logic   counted;
  logic   out_free;
  logic   s1_stall;
  logic   s1_go;
  logic   wrap_hold;
  logic   accept;

  // Handshake: hold a last ballot while the result register is occupied, and
  // take no ballot while the set tag wraps or the memory is being cleared.
  assign out_free  = !m_tvalid || m_tready;
  assign s1_stall  = s1_valid && s1_last && !out_free;
  assign s1_go     = s1_valid && !s1_stall;
  assign wrap_hold = s1_valid && s1_last && (epoch == EPOCH_MAX);
  assign s_tready  = !clearing && !s1_stall && !wrap_hold;
  assign accept    = s_tvalid && s_tready;

  // Count of the staged candidate: forwarded, or from memory if tagged with
  // this set, else zero (left over from an earlier set).
  always_comb begin
    if (fwd_valid && (fwd_addr == s1_cand)) begin
      base_cnt = fwd_cnt;
    end else if (rd_data.tag == epoch) begin
      base_cnt = rd_data.count;
    end else begin
      base_cnt = '0;
    end
  end

  // Saturate at the top count.
  assign cnt_inc = (base_cnt == COUNT_MAX) ? base_cnt : base_cnt + count_t'(1);
  // Candidate zero counts for no one.
  assign counted = (s1_cand != '0);

  always_comb begin
    best_next   = best_count;
    leader_next = leader;
    tied_next   = tied;
    if (counted) begin
      if (cnt_inc > best_count) begin
        best_next   = cnt_inc;
        leader_next = s1_cand;
        tied_next   = 1'b0;
      end else if ((cnt_inc == best_count) && (s1_cand != leader)) begin
        tied_next = 1'b1;
      end
    end
  end

  // Memory write port: clearing sweep or count write-back.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '{tag: '0, count: '0};
    end else if (s1_go && counted) begin
      mem[s1_cand] <= '{tag: epoch, count: cnt_inc};
    end
  end

  // Memory read port: hold the read data while the staged ballot waits.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[s_tdata[CAND_BITS-1:0]];
    end
  end

  // Ballot stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cand <= s_tdata[CAND_BITS-1:0];
      s1_last <= s_tlast;
    end
  end

  // Forwarding register: drop it at the end of a set.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_go) begin
      if (s1_last) begin
        fwd_valid <= 1'b0;
      end else if (counted) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && counted) begin
      fwd_addr <= s1_cand;
      fwd_cnt  <= cnt_inc;
    end
  end

  // Running best count, leader and tie flag; clear them at the end of a set.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_count <= '0;
      leader     <= '0;
      tied       <= 1'b0;
    end else if (s1_go) begin
      if (s1_last) begin
        best_count <= '0;
        leader     <= '0;
        tied       <= 1'b0;
      end else begin
        best_count <= best_next;
        leader     <= leader_next;
        tied       <= tied_next;
      end
    end
  end

  // Set tag and clearing sweep. Advance the tag after each set; when it would
  // wrap, sweep the memory back to tag zero instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      epoch    <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + cand_t'(1);
      if (clr_addr == CAND_MAX) begin
        clearing <= 1'b0;
        epoch    <= '0;
      end
    end else if (s1_go && s1_last) begin
      if (epoch == EPOCH_MAX) begin
        clearing <= 1'b1;
        clr_addr <= '0;
      end else begin
        epoch <= epoch + epoch_t'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go && s1_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      winner <= tied_next ? WINNER_NONE : leader_next;
    end
  end

  assign m_tdata = {{(DATA_BITS - CAND_BITS){1'b0}}, winner};

`ifndef SYNTHESIS
  // No ballot enters while the memory is being swept.
  assert property (@(posedge clk) disable iff (rst) clearing |-> !s_tready)
    else $error("ballot accepted during clearing pass");

  // A set that ends on the last tag starts a clearing pass.
  assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last && (epoch == EPOCH_MAX)) |=> clearing)
    else $error("tag wrap without clearing pass");

  // A forwarded count is always a counted vote.
  assert property (@(posedge clk) disable iff (rst) fwd_valid |-> (fwd_cnt != '0))
    else $error("forwarded count is zero");

  // A tie needs at least one counted vote.
  assert property (@(posedge clk) disable iff (rst) tied |-> (best_count != '0))
    else $error("tie flag set with zero best count");

  // No ballot is staged during the sweep.
  assert property (@(posedge clk) disable iff (rst) clearing |-> !s1_valid)
    else $error("ballot staged during clearing pass");
`endif

endmodule

`default_nettype wire

### verif/histogram_mode_with_tie_unit_test.sv
// Self-checking testbench for the plurality vote histogram unit with tie detection.
`timescale 1ns / 1ps

module histogram_mode_with_tie_unit_test;
  import hmt_pkg::*;

  // Cycles without any transfer before the run is declared hung. This covers the
  // clearing pass, the long receiver hold-off and the longest random gaps.
  localparam int STALL_LIMIT  = 8000;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_SEND_GAP = 24;
  localparam int DRAIN_CYCLES = 8;

  // Width of the candidate pool a random set draws from.
  typedef enum int {POOL_NARROW, POOL_MEDIUM, POOL_FULL} pool_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [DATA_BITS-1:0] s_tdata  = '0;   // [9:0] candidate, rest zero
  logic                 s_tlast  = 1'b0; // last ballot of the set
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [DATA_BITS-1:0] m_tdata;         // [9:0] winner, rest zero

  // Shadow of the block: per-candidate tallies and the running leader state.
  count_t vote_tally [SLOTS];
  count_t top_count;
  cand_t  front_runner;
  bit     tie_seen;
  cand_t  expected_winners [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int mismatch_count = 0;
  int quiet_cycles  = 0;

  histogram_mode_with_tie_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Forget every vote and the leader: the state at reset and after each set.
  function automatic void clear_tally();
    foreach (vote_tally[i]) vote_tally[i] = '0;
    top_count    = '0;
    front_runner = '0;
    tie_seen     = 1'b0;
  endfunction

  // Apply one accepted ballot to the shadow state; queue the winner on the set end.
  function automatic void tally_ballot(input cand_t cand, input bit last);
    count_t c;
    if (cand != '0) begin
      c = vote_tally[cand];
      // Saturate instead of wrapping.
      if (c != COUNT_MAX) c = c + 1'b1;
      vote_tally[cand] = c;
      if (c > top_count) begin
        top_count    = c;
        front_runner = cand;
        tie_seen     = 1'b0;
      end else if (c == top_count && cand != front_runner) begin
        tie_seen = 1'b1;
      end
    end
    if (last) begin
      expected_winners.push_back(tie_seen ? WINNER_NONE : front_runner);
      clear_tally();
    end
  endfunction

  // Offer one ballot and hold it until the transfer. Valid stays high after the
  // transfer so back-to-back ballots never lower and raise it in one step.
  task automatic send_ballot(input cand_t cand, input bit last);
    int gap;
    gap = 0;
    while (gap < MAX_SEND_GAP && send_idle_pct != 0 &&
           $urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      // Idle with junk on the data lines; the block must ignore it.
      s_tvalid <= 1'b0;
      s_tdata  <= DATA_BITS'($urandom);
      s_tlast  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= DATA_BITS'(cand);
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    tally_ballot(cand, last);
  endtask

  // Drop valid and let the clock advance so the next offer lands in a later step.
  task automatic stop_offer();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Pause the sender until every queued winner has been seen.
  task automatic wait_for_results();
    while (expected_winners.size() != 0) @(posedge clk);
  endtask

  // One well-formed set: mostly short, drawn from a narrow, medium or full pool,
  // with the odd ballot for candidate zero mixed in as noise.
  task automatic send_random_set(inout int sent);
    int    len;
    pool_t pool;
    cand_t base;
    cand_t cand;
    if ($urandom_range(99) < 80) len = $urandom_range(1, 6);
    else if ($urandom_range(99) < 75) len = $urandom_range(7, 40);
    else len = $urandom_range(41, 120);
    pool = pool_t'($urandom_range(POOL_FULL));
    base = cand_t'($urandom_range(1, SLOTS - 32));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) cand = '0;
      else begin
        case (pool)
          POOL_NARROW: cand = base + cand_t'($urandom_range(3));
          POOL_MEDIUM: cand = base + cand_t'($urandom_range(31));
          default:     cand = cand_t'($urandom_range(1, SLOTS - 1));
        endcase
      end
      send_ballot(cand, i == len - 1);
    end
    sent += len;
  endtask

  // Field extremes, ties, tie breaks and the candidate zero cases.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_ballot(CAND_MAX, 1'b1);               // highest candidate wins alone
    send_ballot(cand_t'(1), 1'b1);             // lowest candidate wins alone
    send_ballot('0, 1'b1);                     // set with no counted ballot
    send_ballot(cand_t'(5), 1'b0);             // two-way tie
    send_ballot(cand_t'(6), 1'b1);
    send_ballot(cand_t'(7), 1'b0);             // tie, then broken
    send_ballot(cand_t'(8), 1'b0);
    send_ballot(cand_t'(8), 1'b1);
    send_ballot(cand_t'(9), 1'b0);             // leader votes again
    send_ballot(cand_t'(9), 1'b1);
    send_ballot(cand_t'(3), 1'b0);             // zero ignored, its last still ends
    send_ballot('0, 1'b0);
    send_ballot('0, 1'b1);
    send_ballot(cand_t'(10'h2AA), 1'b0);       // alternating bit patterns
    send_ballot(cand_t'(10'h155), 1'b0);
    send_ballot(cand_t'(10'h155), 1'b1);
    send_ballot(cand_t'(11), 1'b0);            // three-way tie
    send_ballot(cand_t'(12), 1'b0);
    send_ballot(CAND_MAX, 1'b1);
    stop_offer();
    wait_for_results();
  endtask

  // Random sets under the given idle rates on both sides.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_items);
    int sent;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < n_items) send_random_set(sent);
    stop_offer();
    wait_for_results();
  endtask

  // Hold the receiver off for a long stretch while short sets keep coming, so a
  // held result stalls the next last ballot; then pause until all results drain.
  task automatic test_backpressure();
    int n;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = HOLD_CYCLES;
    for (int s = 0; s < 12; s++) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        send_ballot(cand_t'($urandom_range(1, 6)), i == n - 1);
    end
    stop_offer();
    wait_for_results();
  endtask

  // Receiver: check every result transfer against the oldest queued winner and
  // pick the next ready value (hold-off first, then random idling).
  always @(posedge clk) begin
    cand_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_winners.size() == 0) begin
          report_mismatch($sformatf("result 0x%0h with none expected", m_tdata));
        end else begin
          want = expected_winners.pop_front();
          if (m_tdata !== DATA_BITS'(want))
            report_mismatch($sformatf("winner 0x%0h, expected 0x%0h", m_tdata, want));
        end
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_tally();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic(31, 53, 330);
    test_random_traffic(53, 31, 330);
    test_backpressure();
    test_random_traffic(0, 0, 330);

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
src/hmt_pkg.sv
src/histogram_mode_with_tie_unit.sv
verif/histogram_mode_with_tie_unit_test.sv
